### rtl/tdpm_pkg.sv
package tdpm_pkg;

   // default sizes of the pattern block and the text grid
   localparam int MAX_PATTERN_ROWS_DEF = 8;
   localparam int MAX_PATTERN_COLS_DEF = 16;
   localparam int MAX_LINE_LENGTH_DEF  = 1024;
   localparam longint MAX_TEXT_ROWS_DEF = 64'd65536;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // fixed field widths of the request and response channels
   localparam int OPCODE_W    = 2;
   localparam int PAT_ROW_W   = 3;
   localparam int PAT_COL_W   = 4;
   localparam int SYMBOL_W    = 8;
   localparam int MATCH_ROW_W = 16;
   localparam int MATCH_COL_W = 10;
   localparam int CSR_INDEX_W = 2;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TEXT    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_USED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_USED = 2'd1;

   // top-left corner of a found block
   typedef struct packed {
      logic [MATCH_ROW_W-1:0] row;
      logic [MATCH_COL_W-1:0] col;
   } tdpm_coord_type;

endpackage

### rtl/two_d_exact_pattern_match.sv
// Two-dimensional exact pattern match.
// Request channel (req_): opcode 0 loads one pattern character at pattern_row and
// pattern_col, opcode 1 streams one text character with end_of_line on the last
// character of a text row, opcode 2 restarts the text grid (pattern and sizes kept).
// Register channel (csr_): index 0 sets the pattern height, index 1 the width,
// both saturated into their legal range; csr_ready is always high.
// Response channel (rsp_): one transfer per found block, carrying the zero-based
// top-left row and column; overlapping blocks are all reported, in text order.
// Throughput is one request per cycle while the queue has room. A text character's
// response passes the queue between front and back, the stage register fed by the
// registered read of the column-mask memory and the output register; same-column
// updates on consecutive cycles are bypassed so the rate holds.
// Reset clears counters, the window and the sizes (1 by 1); the column masks need
// no clearing pass, as a column the previous row did not reach reads as empty.
// When the receiver stalls, one result waits in the output register, further
// characters pile up in the queue and req_ready drops once it is full.
module two_d_exact_pattern_match #(
   parameter int     MAX_PATTERN_ROWS = tdpm_pkg::MAX_PATTERN_ROWS_DEF,
   parameter int     MAX_PATTERN_COLS = tdpm_pkg::MAX_PATTERN_COLS_DEF,
   parameter int     MAX_LINE_LENGTH  = tdpm_pkg::MAX_LINE_LENGTH_DEF,
   parameter longint MAX_TEXT_ROWS    = tdpm_pkg::MAX_TEXT_ROWS_DEF,
   parameter int     ROWS_W           = $clog2(MAX_PATTERN_ROWS + 1),
   parameter int     COLS_W           = $clog2(MAX_PATTERN_COLS + 1),
   parameter int     CSR_DATA_W       = (ROWS_W > COLS_W) ? ROWS_W : COLS_W
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tdpm_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [tdpm_pkg::PAT_ROW_W-1:0]     req_pattern_row,
   input  logic [tdpm_pkg::PAT_COL_W-1:0]     req_pattern_col,
   input  logic [tdpm_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic                               req_end_of_line,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tdpm_pkg::MATCH_ROW_W-1:0]   rsp_match_row,
   output logic [tdpm_pkg::MATCH_COL_W-1:0]   rsp_match_col,
   // register channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tdpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]              csr_wdata
);

   localparam int COL_W   = $clog2(MAX_LINE_LENGTH);
   localparam int COORD_W = $bits(tdpm_pkg::tdpm_coord_type);
   localparam int ENTRY_W = COL_W + 1 + MAX_PATTERN_ROWS + COORD_W;

   logic                          q_full;
   logic                          q_empty;
   logic                          q_push;
   logic                          q_pop;
   logic [COL_W-1:0]              q_col;
   logic                          q_prev_valid;
   logic [MAX_PATTERN_ROWS-1:0]   q_hits;
   tdpm_pkg::tdpm_coord_type      q_coord;
   logic [ENTRY_W-1:0]            push_data;
   logic [ENTRY_W-1:0]            head_data;
   logic [COL_W-1:0]              head_col;
   logic                          head_prev_valid;
   logic [MAX_PATTERN_ROWS-1:0]   head_hits;
   tdpm_pkg::tdpm_coord_type      head_coord;
   logic [ROWS_W-1:0]             rows_used;

   assign csr_ready = 1'b1;

   // front: registers, pattern store, window compare
   tdpm_front #(
      .MAX_PATTERN_ROWS (MAX_PATTERN_ROWS),
      .MAX_PATTERN_COLS (MAX_PATTERN_COLS),
      .MAX_LINE_LENGTH  (MAX_LINE_LENGTH),
      .MAX_TEXT_ROWS    (MAX_TEXT_ROWS),
      .ROWS_W           (ROWS_W),
      .COLS_W           (COLS_W),
      .CSR_DATA_W       (CSR_DATA_W),
      .COL_W            (COL_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pattern_row (req_pattern_row),
      .req_pattern_col (req_pattern_col),
      .req_symbol      (req_symbol),
      .req_end_of_line (req_end_of_line),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_col           (q_col),
      .q_prev_valid    (q_prev_valid),
      .q_hits          (q_hits),
      .q_coord         (q_coord),
      .rows_used       (rows_used)
   );

   // queue between front and back
   assign push_data = {q_col, q_prev_valid, q_hits, q_coord};

   tdpm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (tdpm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (head_data)
   );

   assign {head_col, head_prev_valid, head_hits, head_coord} = head_data;

   // back: column-mask update and result register
   tdpm_back #(
      .MAX_PATTERN_ROWS (MAX_PATTERN_ROWS),
      .MAX_LINE_LENGTH  (MAX_LINE_LENGTH),
      .ROWS_W           (ROWS_W),
      .COL_W            (COL_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .head_col        (head_col),
      .head_prev_valid (head_prev_valid),
      .head_hits       (head_hits),
      .head_coord      (head_coord),
      .rows_used       (rows_used),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_row   (rsp_match_row),
      .rsp_match_col   (rsp_match_col)
   );

endmodule

### rtl/tdpm_ram.sv
module tdpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port, read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tdpm_queue.sv
module tdpm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (32'(count_ff) == 32'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == 32'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == 32'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

endmodule

### rtl/tdpm_front.sv
module tdpm_front #(
   parameter int     MAX_PATTERN_ROWS = tdpm_pkg::MAX_PATTERN_ROWS_DEF,
   parameter int     MAX_PATTERN_COLS = tdpm_pkg::MAX_PATTERN_COLS_DEF,
   parameter int     MAX_LINE_LENGTH  = tdpm_pkg::MAX_LINE_LENGTH_DEF,
   parameter longint MAX_TEXT_ROWS    = tdpm_pkg::MAX_TEXT_ROWS_DEF,
   parameter int     ROWS_W           = $clog2(MAX_PATTERN_ROWS + 1),
   parameter int     COLS_W           = $clog2(MAX_PATTERN_COLS + 1),
   parameter int     CSR_DATA_W       = (ROWS_W > COLS_W) ? ROWS_W : COLS_W,
   parameter int     COL_W            = $clog2(MAX_LINE_LENGTH)
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tdpm_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [tdpm_pkg::PAT_ROW_W-1:0]     req_pattern_row,
   input  logic [tdpm_pkg::PAT_COL_W-1:0]     req_pattern_col,
   input  logic [tdpm_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic                               req_end_of_line,
   // register writes
   input  logic                               csr_valid,
   input  logic [tdpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]              csr_wdata,
   // queue side
   input  logic                               q_full,
   output logic                               q_push,
   output logic [COL_W-1:0]                   q_col,
   output logic                               q_prev_valid,
   output logic [MAX_PATTERN_ROWS-1:0]        q_hits,
   output tdpm_pkg::tdpm_coord_type           q_coord,
   // pattern height for the back end
   output logic [ROWS_W-1:0]                  rows_used
);

   localparam int COL_CNT_W = $clog2(MAX_LINE_LENGTH + 1);
   localparam int ROW_W     = $clog2(MAX_TEXT_ROWS);
   localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(MAX_TEXT_ROWS - 64'd1);

   logic [tdpm_pkg::SYMBOL_W-1:0] pat_ff [MAX_PATTERN_ROWS][MAX_PATTERN_COLS];
   logic [tdpm_pkg::SYMBOL_W-1:0] win_ff [MAX_PATTERN_COLS];
   logic [tdpm_pkg::SYMBOL_W-1:0] win_in [MAX_PATTERN_COLS];
   logic [tdpm_pkg::SYMBOL_W-1:0] win_sh [MAX_PATTERN_COLS];
   logic [tdpm_pkg::SYMBOL_W-1:0] aligned [MAX_PATTERN_COLS];
   logic [COL_CNT_W-1:0]          col_cnt_ff, col_cnt_in;
   logic [COL_CNT_W-1:0]          prev_len_ff, prev_len_in;
   logic [ROW_W-1:0]              row_cnt_ff, row_cnt_in;
   logic [ROWS_W-1:0]             rows_used_ff, rows_used_in;
   logic [COLS_W-1:0]             cols_used_ff, cols_used_in;
   logic                          accept;
   logic                          in_line;
   logic                          window_full;
   logic                          hit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign in_line   = (32'(col_cnt_ff) < 32'(MAX_LINE_LENGTH));
   assign rows_used = rows_used_ff;

   // register writes saturate into the legal size range
   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tdpm_pkg::CSR_ROWS_USED: begin
               if (csr_wdata == '0) begin
                  rows_used_in = ROWS_W'(1);
               end else if (32'(csr_wdata) > 32'(MAX_PATTERN_ROWS)) begin
                  rows_used_in = ROWS_W'(MAX_PATTERN_ROWS);
               end else begin
                  rows_used_in = ROWS_W'(csr_wdata);
               end
            end
            tdpm_pkg::CSR_COLS_USED: begin
               if (csr_wdata == '0) begin
                  cols_used_in = COLS_W'(1);
               end else if (32'(csr_wdata) > 32'(MAX_PATTERN_COLS)) begin
                  cols_used_in = COLS_W'(MAX_PATTERN_COLS);
               end else begin
                  cols_used_in = COLS_W'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // window shifted by the incoming character, newest at index zero
   always_comb begin
      win_sh[0] = req_symbol;
      for (int k = 1; k < MAX_PATTERN_COLS; k++) begin
         win_sh[k] = win_ff[k-1];
      end
   end

   // window slot facing pattern column c
   always_comb begin
      for (int c = 0; c < MAX_PATTERN_COLS; c++) begin
         aligned[c] = '0;
         for (int k = 0; k < MAX_PATTERN_COLS; k++) begin
            if (32'(k) + 32'(c) + 32'd1 == 32'(cols_used_ff)) begin
               aligned[c] = win_sh[k];
            end
         end
      end
   end

   // parallel compare of the window with every pattern row
   assign window_full = (32'(col_cnt_ff) + 32'd1 >= 32'(cols_used_ff));

   always_comb begin
      hit = 1'b0;
      for (int r = 0; r < MAX_PATTERN_ROWS; r++) begin
         hit = window_full && (32'(r) < 32'(rows_used_ff));
         for (int c = 0; c < MAX_PATTERN_COLS; c++) begin
            if ((32'(c) < 32'(cols_used_ff)) && (pat_ff[r][c] != aligned[c])) begin
               hit = 1'b0;
            end
         end
         q_hits[r] = hit;
      end
   end

   // queue entry for a text character inside the line limit
   assign q_push       = accept && (req_opcode == tdpm_pkg::OP_TEXT) && in_line;
   assign q_col        = col_cnt_ff[COL_W-1:0];
   assign q_prev_valid = (col_cnt_ff < prev_len_ff);
   assign q_coord.row  = tdpm_pkg::MATCH_ROW_W'(row_cnt_ff)
                         - tdpm_pkg::MATCH_ROW_W'(rows_used_ff)
                         + tdpm_pkg::MATCH_ROW_W'(1);
   assign q_coord.col  = tdpm_pkg::MATCH_COL_W'(32'(col_cnt_ff) + 32'd1
                                                 - 32'(cols_used_ff));

   // row, column and window bookkeeping
   always_comb begin
      win_in      = win_ff;
      col_cnt_in  = col_cnt_ff;
      prev_len_in = prev_len_ff;
      row_cnt_in  = row_cnt_ff;
      if (accept) begin
         unique case (req_opcode)
            tdpm_pkg::OP_TEXT: begin
               if (in_line) begin
                  win_in     = win_sh;
                  col_cnt_in = col_cnt_ff + COL_CNT_W'(1);
               end
               if (req_end_of_line) begin
                  prev_len_in = col_cnt_in;
                  col_cnt_in  = '0;
                  for (int k = 0; k < MAX_PATTERN_COLS; k++) begin
                     win_in[k] = '0;
                  end
                  if (row_cnt_ff != ROW_TOP) begin
                     row_cnt_in = row_cnt_ff + ROW_W'(1);
                  end
               end
            end
            tdpm_pkg::OP_RESTART: begin
               col_cnt_in  = '0;
               prev_len_in = '0;
               row_cnt_in  = '0;
               for (int k = 0; k < MAX_PATTERN_COLS; k++) begin
                  win_in[k] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN_COLS; k++) begin
            win_ff[k] <= '0;
         end
         col_cnt_ff   <= '0;
         prev_len_ff  <= '0;
         row_cnt_ff   <= '0;
         rows_used_ff <= ROWS_W'(1);
         cols_used_ff <= COLS_W'(1);
      end else begin
         win_ff       <= win_in;
         col_cnt_ff   <= col_cnt_in;
         prev_len_ff  <= prev_len_in;
         row_cnt_ff   <= row_cnt_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
      end
   end

   // pattern store, positions beyond the limits are dropped
   always_ff @(posedge clock) begin
      for (int r = 0; r < MAX_PATTERN_ROWS; r++) begin
         for (int c = 0; c < MAX_PATTERN_COLS; c++) begin
            if (accept && (req_opcode == tdpm_pkg::OP_LOAD)
                && (32'(req_pattern_row) == 32'(r)) && (32'(req_pattern_col) == 32'(c))) begin
               pat_ff[r][c] <= req_symbol;
            end
         end
      end
   end

   a_col_in_limit: assert property (@(posedge clock) disable iff (reset)
      (32'(col_cnt_ff) <= 32'(MAX_LINE_LENGTH)) && (prev_len_ff <= COL_CNT_W'(MAX_LINE_LENGTH)))
      else $error("column count beyond line limit");

   a_row_saturates: assert property (@(posedge clock) disable iff (reset)
      (row_cnt_ff == ROW_TOP) && !(accept && (req_opcode == tdpm_pkg::OP_RESTART))
      |=> (row_cnt_ff == ROW_TOP))
      else $error("row count left its top value without restart");

endmodule

### rtl/tdpm_back.sv
module tdpm_back #(
   parameter int MAX_PATTERN_ROWS = tdpm_pkg::MAX_PATTERN_ROWS_DEF,
   parameter int MAX_LINE_LENGTH  = tdpm_pkg::MAX_LINE_LENGTH_DEF,
   parameter int ROWS_W           = $clog2(MAX_PATTERN_ROWS + 1),
   parameter int COL_W            = $clog2(MAX_LINE_LENGTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // queue head
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  logic [COL_W-1:0]                     head_col,
   input  logic                                 head_prev_valid,
   input  logic [MAX_PATTERN_ROWS-1:0]          head_hits,
   input  tdpm_pkg::tdpm_coord_type             head_coord,
   input  logic [ROWS_W-1:0]                    rows_used,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tdpm_pkg::MATCH_ROW_W-1:0]     rsp_match_row,
   output logic [tdpm_pkg::MATCH_COL_W-1:0]     rsp_match_col
);

   localparam logic [MAX_PATTERN_ROWS-1:0] ONE = MAX_PATTERN_ROWS'(1);

   logic                          s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]              s1_col_ff;
   logic                          s1_prev_valid_ff;
   logic [MAX_PATTERN_ROWS-1:0]   s1_hits_ff;
   tdpm_pkg::tdpm_coord_type      s1_coord_ff;
   logic                          fwd_ff, fwd_in;
   logic [MAX_PATTERN_ROWS-1:0]   fwd_data_ff;
   logic                          out_valid_ff, out_valid_in;
   tdpm_pkg::tdpm_coord_type      out_coord_ff;
   logic [MAX_PATTERN_ROWS-1:0]   ram_rd_data;
   logic [MAX_PATTERN_ROWS-1:0]   prev_mask;
   logic [MAX_PATTERN_ROWS-1:0]   next_mask;
   logic [MAX_PATTERN_ROWS-1:0]   top_mask;
   logic                          s1_match;
   logic                          s1_adv;

   // column masks, one per text column
   tdpm_ram #(
      .WIDTH (MAX_PATTERN_ROWS),
      .DEPTH (MAX_LINE_LENGTH)
   ) u_masks (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (next_mask),
      .rd_en   (q_pop),
      .rd_addr (head_col),
      .rd_data (ram_rd_data)
   );

   // bit of the last pattern row
   always_comb begin
      for (int i = 0; i < MAX_PATTERN_ROWS; i++) begin
         top_mask[i] = (32'(rows_used) == 32'(i) + 32'd1);
      end
   end

   // mask update, bypassing the same-column write of the entry just ahead of it
   always_comb begin
      if (!s1_prev_valid_ff) begin
         prev_mask = '0;
      end else if (fwd_ff) begin
         prev_mask = fwd_data_ff;
      end else begin
         prev_mask = ram_rd_data;
      end
      next_mask = ((prev_mask << 1) | ONE) & s1_hits_ff;
   end

   assign s1_match = |(next_mask & top_mask);
   assign s1_adv   = s1_valid_ff && (!s1_match || !out_valid_ff || rsp_ready);
   assign q_pop    = !q_empty && (!s1_valid_ff || s1_adv);

   // stage and output control
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      fwd_in       = fwd_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
         fwd_in      = s1_adv && (s1_col_ff == head_col);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
         fwd_in      = 1'b0;
      end
      out_valid_in = (s1_adv && s1_match) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage and output payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_col_ff        <= head_col;
         s1_prev_valid_ff <= head_prev_valid;
         s1_hits_ff       <= head_hits;
         s1_coord_ff      <= head_coord;
         fwd_data_ff      <= next_mask;
      end
      if (s1_adv && s1_match) begin
         out_coord_ff <= s1_coord_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_match_row = out_coord_ff.row;
   assign rsp_match_col = out_coord_ff.col;

   a_fwd_same_col: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (s1_valid_ff && (s1_col_ff == $past(s1_col_ff))))
      else $error("bypass taken for a different column");

   a_fresh_col_depth: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_prev_valid_ff) |-> ((next_mask >> 1) == '0))
      else $error("column without a previous row reached past the first pattern row");

endmodule

### test/tb_two_d_exact_pattern_match.sv
module tb_two_d_exact_pattern_match;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_W         = $clog2(tdpm_pkg::MAX_PATTERN_COLS_DEF + 1);
   localparam int PAT_ROWS      = tdpm_pkg::MAX_PATTERN_ROWS_DEF;
   localparam int PAT_COLS      = tdpm_pkg::MAX_PATTERN_COLS_DEF;
   localparam int LINE_LIMIT    = tdpm_pkg::MAX_LINE_LENGTH_DEF;
   localparam int ROW_LIMIT     = int'(tdpm_pkg::MAX_TEXT_ROWS_DEF);
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int STALL_CYCLES  = 200;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int IDLE_PCT      = 14;

   // opcode with no function in the block
   localparam logic [tdpm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [tdpm_pkg::OPCODE_W-1:0]  opcode;
      logic [tdpm_pkg::PAT_ROW_W-1:0] prow;
      logic [tdpm_pkg::PAT_COL_W-1:0] pcol;
      logic [tdpm_pkg::SYMBOL_W-1:0]  symbol;
      logic                           eol;
   } grid_request_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [tdpm_pkg::OPCODE_W-1:0]    req_opcode = tdpm_pkg::OP_LOAD;
   logic [tdpm_pkg::PAT_ROW_W-1:0]   req_pattern_row = '0;
   logic [tdpm_pkg::PAT_COL_W-1:0]   req_pattern_col = '0;
   logic [tdpm_pkg::SYMBOL_W-1:0]    req_symbol = '0;
   logic                             req_end_of_line = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [tdpm_pkg::MATCH_ROW_W-1:0] rsp_match_row;
   logic [tdpm_pkg::MATCH_COL_W-1:0] rsp_match_col;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tdpm_pkg::CSR_INDEX_W-1:0] csr_index = tdpm_pkg::CSR_ROWS_USED;
   logic [CSR_W-1:0]                 csr_wdata = '0;

   // matcher state mirrored by the testbench
   logic [tdpm_pkg::SYMBOL_W-1:0] pat_store [PAT_ROWS][PAT_COLS];
   logic [tdpm_pkg::SYMBOL_W-1:0] window [PAT_COLS];
   logic [PAT_ROWS-1:0]           col_mask [LINE_LIMIT];
   int                            row_count;
   int                            col_count;
   int                            prev_len;
   int                            rows_used = 1;
   int                            cols_used = 1;

   // generator copy of the pattern, used to plant blocks in the text
   logic [tdpm_pkg::SYMBOL_W-1:0] pattern_copy [PAT_ROWS][PAT_COLS];

   grid_request_type         pending_requests [$];
   tdpm_pkg::tdpm_coord_type pending_corners [$];
   int                       mismatches = 0;
   int                       cycle_count = 0;
   bit                       no_gaps = 1'b0;
   int                       stall_request = 0;
   int                       stall_seen = 0;
   int                       stall_left = 0;

   two_d_exact_pattern_match u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pattern_row (req_pattern_row),
      .req_pattern_col (req_pattern_col),
      .req_symbol      (req_symbol),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_row   (rsp_match_row),
      .rsp_match_col   (rsp_match_col),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // wipe the text side: window, column masks and counters
   function automatic void clear_text();
      for (int k = 0; k < PAT_COLS; k++) window[k] = '0;
      for (int k = 0; k < LINE_LIMIT; k++) col_mask[k] = '0;
      row_count = 0;
      col_count = 0;
      prev_len  = 0;
   endfunction

   function automatic int clamp_size(int value, int top);
      if (value < 1) return 1;
      if (value > top) return top;
      return value;
   endfunction

   // one text character: shift window, compare rows, update the column mask
   function automatic void find_corners(logic [tdpm_pkg::SYMBOL_W-1:0] sym, logic eol);
      int                       col;
      logic [PAT_ROWS-1:0]      hits;
      logic [PAT_ROWS-1:0]      prev_bits;
      logic [PAT_ROWS-1:0]      next_bits;
      logic                     same;
      tdpm_pkg::tdpm_coord_type corner;
      if (col_count < LINE_LIMIT) begin
         col = col_count;
         for (int k = PAT_COLS - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = sym;
         hits = '0;
         // no row can match before the window is full
         if (col + 1 >= cols_used) begin
            for (int r = 0; r < rows_used; r++) begin
               same = 1'b1;
               for (int c = 0; c < cols_used; c++) begin
                  if (pat_store[r][c] !== window[cols_used-1-c]) same = 1'b0;
               end
               hits[r] = same;
            end
         end
         // columns the previous row never reached hold no progress
         prev_bits = (col < prev_len) ? col_mask[col] : '0;
         next_bits = ((prev_bits << 1) | PAT_ROWS'(1)) & hits;
         col_mask[col] = next_bits;
         if (next_bits[rows_used-1]) begin
            corner.row = tdpm_pkg::MATCH_ROW_W'(row_count - rows_used + 1);
            corner.col = tdpm_pkg::MATCH_COL_W'(col + 1 - cols_used);
            pending_corners.push_back(corner);
         end
         col_count = col + 1;
      end
      // end of row still counts for dropped characters past the line limit
      if (eol) begin
         prev_len  = col_count;
         col_count = 0;
         for (int k = 0; k < PAT_COLS; k++) window[k] = '0;
         if (row_count < ROW_LIMIT - 1) row_count++;
      end
   endfunction

   function automatic void follow_request(grid_request_type item);
      case (item.opcode)
         tdpm_pkg::OP_LOAD: begin
            pat_store[item.prow][item.pcol] = item.symbol;
         end
         tdpm_pkg::OP_TEXT: begin
            find_corners(item.symbol, item.eol);
         end
         tdpm_pkg::OP_RESTART: begin
            clear_text();
         end
         default: begin
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      grid_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            item.opcode = req_opcode;
            item.prow   = req_pattern_row;
            item.pcol   = req_pattern_col;
            item.symbol = req_symbol;
            item.eol    = req_end_of_line;
            follow_request(item);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 &&
                (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
               item = pending_requests.pop_front();
               req_opcode      <= item.opcode;
               req_pattern_row <= item.prow;
               req_pattern_col <= item.pcol;
               req_symbol      <= item.symbol;
               req_end_of_line <= item.eol;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_seen != stall_request) begin
         stall_seen = stall_request;
         stall_left = STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // result checker
   always @(posedge clock) begin
      tdpm_pkg::tdpm_coord_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_corners.size() == 0) begin
            $display("%0t: unexpected match, expected none, actual row %0d col %0d",
                     $time, rsp_match_row, rsp_match_col);
            mismatches++;
         end else begin
            want = pending_corners.pop_front();
            if (want.row !== rsp_match_row) begin
               $display("%0t: match_row expected %0d actual %0d",
                        $time, want.row, rsp_match_row);
               mismatches++;
            end
            if (want.col !== rsp_match_col) begin
               $display("%0t: match_col expected %0d actual %0d",
                        $time, want.col, rsp_match_col);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_request(logic [tdpm_pkg::OPCODE_W-1:0] op,
                               logic [tdpm_pkg::PAT_ROW_W-1:0] prow,
                               logic [tdpm_pkg::PAT_COL_W-1:0] pcol,
                               logic [tdpm_pkg::SYMBOL_W-1:0] sym,
                               logic eol);
      grid_request_type item;
      item.opcode = op;
      item.prow   = prow;
      item.pcol   = pcol;
      item.symbol = sym;
      item.eol    = eol;
      pending_requests.push_back(item);
   endtask

   task automatic push_text(logic [tdpm_pkg::SYMBOL_W-1:0] sym, logic eol);
      push_request(tdpm_pkg::OP_TEXT,
                   tdpm_pkg::PAT_ROW_W'($urandom_range(PAT_ROWS - 1)),
                   tdpm_pkg::PAT_COL_W'($urandom_range(PAT_COLS - 1)),
                   sym, eol);
   endtask

   // restart or unused opcode with junk in every other field
   task automatic push_other(logic [tdpm_pkg::OPCODE_W-1:0] op);
      push_request(op,
                   tdpm_pkg::PAT_ROW_W'($urandom_range(PAT_ROWS - 1)),
                   tdpm_pkg::PAT_COL_W'($urandom_range(PAT_COLS - 1)),
                   tdpm_pkg::SYMBOL_W'($urandom_range(255)),
                   1'($urandom_range(1)));
   endtask

   // small alphabet so that rows line up often, a few arbitrary bytes as noise
   function automatic logic [tdpm_pkg::SYMBOL_W-1:0] text_symbol(int alpha, int noise_pct);
      if ($urandom_range(99) < noise_pct) return tdpm_pkg::SYMBOL_W'($urandom_range(255));
      return tdpm_pkg::SYMBOL_W'("a" + $urandom_range(alpha - 1));
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || pending_corners.size() != 0);
   endtask

   task automatic write_size(logic [tdpm_pkg::CSR_INDEX_W-1:0] index, int value);
      wait_idle();
      // a character with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_W-1:0];
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == tdpm_pkg::CSR_ROWS_USED) begin
         rows_used = clamp_size(int'(value[CSR_W-1:0]), PAT_ROWS);
      end else if (index == tdpm_pkg::CSR_COLS_USED) begin
         cols_used = clamp_size(int'(value[CSR_W-1:0]), PAT_COLS);
      end
   endtask

   task automatic load_pattern(int alpha);
      for (int r = 0; r < rows_used; r++) begin
         for (int c = 0; c < cols_used; c++) begin
            pattern_copy[r][c] = text_symbol(alpha, 0);
            push_request(tdpm_pkg::OP_LOAD, tdpm_pkg::PAT_ROW_W'(r),
                         tdpm_pkg::PAT_COL_W'(c), pattern_copy[r][c],
                         1'($urandom_range(1)));
         end
      end
   endtask

   // text grid with the pattern planted a few times, ragged row ends and noise
   task automatic stream_grid(int n_rows, int width, int alpha, int plants);
      logic [tdpm_pkg::SYMBOL_W-1:0] grid [64][64];
      int                            row_len [64];
      int                            r0;
      int                            c0;
      for (int r = 0; r < n_rows; r++) begin
         row_len[r] = width;
         if ($urandom_range(3) == 0) row_len[r] = width - $urandom_range(width > 3 ? 3 : width - 1);
         for (int c = 0; c < width; c++) grid[r][c] = text_symbol(alpha, 4);
      end
      for (int p = 0; p < plants; p++) begin
         r0 = $urandom_range(n_rows - rows_used);
         c0 = $urandom_range(width - cols_used);
         for (int r = 0; r < rows_used; r++) begin
            for (int c = 0; c < cols_used; c++) grid[r0+r][c0+c] = pattern_copy[r][c];
            if (row_len[r0+r] < c0 + cols_used) row_len[r0+r] = c0 + cols_used;
         end
      end
      for (int r = 0; r < n_rows; r++) begin
         for (int c = 0; c < row_len[r]; c++) begin
            if ($urandom_range(99) == 0) push_other(tdpm_pkg::OP_RESTART);
            else if ($urandom_range(99) == 0) push_other(OP_UNUSED);
            push_text(grid[r][c], c == row_len[r] - 1);
         end
      end
   endtask

   task automatic run_phase(int rows_val, int cols_val, int alpha);
      int n_rows;
      int width;
      write_size(tdpm_pkg::CSR_ROWS_USED, rows_val);
      write_size(tdpm_pkg::CSR_COLS_USED, cols_val);
      load_pattern(alpha);
      if ($urandom_range(3) != 0) push_other(tdpm_pkg::OP_RESTART);
      n_rows = rows_used + $urandom_range(1, 4);
      width  = cols_used + $urandom_range(1, 8);
      stream_grid(n_rows, width, alpha, 2 + $urandom_range(3));
      wait_idle();
   endtask

   initial begin
      int waited;
      clear_text();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: 1x1 pattern, extreme symbols and positions
      push_request(tdpm_pkg::OP_LOAD, tdpm_pkg::PAT_ROW_W'(PAT_ROWS - 1),
                   tdpm_pkg::PAT_COL_W'(PAT_COLS - 1), 8'h00, 1'b1);
      push_request(tdpm_pkg::OP_LOAD, 3'd0, 4'd0, 8'hFF, 1'b0);
      push_text(8'hFF, 1'b0);
      push_text(8'h00, 1'b0);
      push_text(8'hFF, 1'b1);
      push_other(OP_UNUSED);
      push_text(8'h7F, 1'b0);
      push_text(8'hFF, 1'b1);
      push_other(tdpm_pkg::OP_RESTART);
      push_text(8'hFF, 1'b1);

      // directed: 2x2 block, then a stale mask past a short previous row
      write_size(tdpm_pkg::CSR_ROWS_USED, 2);
      write_size(tdpm_pkg::CSR_COLS_USED, 2);
      push_request(tdpm_pkg::OP_LOAD, 3'd0, 4'd0, "a", 1'b0);
      push_request(tdpm_pkg::OP_LOAD, 3'd0, 4'd1, "b", 1'b0);
      push_request(tdpm_pkg::OP_LOAD, 3'd1, 4'd0, "c", 1'b0);
      push_request(tdpm_pkg::OP_LOAD, 3'd1, 4'd1, "d", 1'b0);
      push_other(tdpm_pkg::OP_RESTART);
      push_text("a", 1'b0);
      push_text("b", 1'b0);
      push_text("a", 1'b0);
      push_text("b", 1'b1);
      push_text("c", 1'b0);
      push_text("d", 1'b1);
      push_text("x", 1'b0);
      push_text("x", 1'b0);
      push_text("c", 1'b0);
      push_text("d", 1'b1);

      // random grids over several sizes, extremes and saturated writes among them
      run_phase(2, 3, 2);
      run_phase(31, 31, 2);
      run_phase(8, 1, 3);
      run_phase(0, 16, 2);
      no_gaps = 1'b1;
      run_phase(4, 4, 2);
      no_gaps = 1'b0;
      run_phase(3, 0, 4);
      run_phase($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(1, 3));

      // receiver holds off while every character matches, so the input backs up
      write_size(tdpm_pkg::CSR_ROWS_USED, 1);
      write_size(tdpm_pkg::CSR_COLS_USED, 1);
      push_request(tdpm_pkg::OP_LOAD, 3'd0, 4'd0, "a", 1'b0);
      wait_idle();
      @(negedge clock) stall_request++;
      repeat (60) push_text("a", $urandom_range(9) == 0);
      wait_idle();

      // drain
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid);
      waited = 0;
      while (pending_corners.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_corners.size() != 0) begin
         $display("%0t: %0d expected matches never reported", $time,
                  pending_corners.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
